// ===== design/dep_pkg.sv =====
// Package: opcodes, cell control struct and size constants for the double-ended priority queue.
package dep_pkg;

  localparam int DefCapacity = 64;
  localparam int KeyW        = 32;
  localparam int OpW         = 2;
  localparam int CountOutW   = 7;

  typedef enum logic [OpW-1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_MAX = 2'd1,
    OP_DEL_MIN = 2'd2
  } opcode_e;

  typedef struct packed {
    logic ins;
    logic del_min;
  } cell_ctl_t;

endpackage

// ===== design/dep_cell.sv =====
// One cell of the sorted key chain: holds one key and moves it with its neighbors.
module dep_cell (
  input  logic                              clk_i,
  input  dep_pkg::cell_ctl_t                ctl_i,
  input  logic signed [dep_pkg::KeyW-1:0]   key_i,
  input  logic                              occ_i,
  input  logic signed [dep_pkg::KeyW-1:0]   left_key_i,
  input  logic                              left_gt_i,
  input  logic signed [dep_pkg::KeyW-1:0]   right_key_i,
  output logic signed [dep_pkg::KeyW-1:0]   key_o,
  output logic                              gt_o
);

  logic signed [dep_pkg::KeyW-1:0] key_q, key_d;
  logic                            gt;

  assign gt = occ_i && (key_q > key_i);

  always_comb begin
    key_d = key_q;
    if (ctl_i.ins) begin
      if (left_gt_i) begin
        key_d = left_key_i;
      end else if (gt || !occ_i) begin
        key_d = key_i;
      end
    end else if (ctl_i.del_min) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign gt_o  = gt;

endmodule

// ===== design/double_ended_priority_queue.sv =====
// Top level: double-ended priority queue built as a sorted chain of key cells.
// Keys sit in ascending order in a row of CAPACITY cells; an insert finds its place by a
// compare in every cell and shifts the larger keys up one cell, a delete-smallest shifts
// every key down one cell, and a delete-largest only lowers the count. One operation is
// taken per cycle, unless a result still waits for a master side that holds m_axis_tready low.
// The chain and count register an operation at its transfer; the output register then
// captures the result once the master side can take it, and m_axis_tvalid is raised.
// Deletes on an empty queue change nothing; an insert into a full queue is dropped and
// flagged. Largest and smallest read 0 when the queue is empty.
module double_ended_priority_queue #(
  parameter int CAPACITY = dep_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // [31:0] largest_key, [63:32] smallest_key,
                                      // [70:64] entry_count, [71] insert_dropped
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int KW   = dep_pkg::KeyW;

  logic                   accept;
  logic                   move;
  logic                   full;
  logic                   empty;
  logic                   dropped;
  dep_pkg::opcode_e       opcode;
  dep_pkg::cell_ctl_t     ctl;
  logic [CntW-1:0]        count_q, count_d;
  logic                   pend_q, pend_d;
  logic                   pend_drop_q;
  logic                   out_valid_q, out_valid_d;
  logic [71:0]            out_data_q;

  logic signed [KW-1:0]   key_in;
  logic signed [KW-1:0]   key_w [CAPACITY];
  logic                   gt_w  [CAPACITY];
  logic                   occ   [CAPACITY];
  logic [CAPACITY-1:0]    top;
  logic [KW-1:0]          largest;
  logic [KW-1:0]          smallest;
  logic [CntW+6:0]        cnt_ext;

  assign key_in = s_axis_tdata;
  assign opcode = dep_pkg::opcode_e'(s_axis_tuser);
  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);

  assign move          = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_q || move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctl         = '0;
    dropped     = 1'b0;
    count_d     = count_q;
    case (opcode)
      dep_pkg::OP_INSERT: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          ctl.ins = accept;
          if (accept) count_d = count_q + 1'b1;
        end
      end
      dep_pkg::OP_DEL_MAX: begin
        if (accept && !empty) count_d = count_q - 1'b1;
      end
      dep_pkg::OP_DEL_MIN: begin
        if (!empty) begin
          ctl.del_min = accept;
          if (accept) count_d = count_q - 1'b1;
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [KW-1:0] left_key;
      logic                 left_gt;
      logic signed [KW-1:0] right_key;

      assign occ[gi] = (CntW'(gi) < count_q);

      if (gi == 0) begin : g_first
        assign left_key = key_w[gi];
        assign left_gt  = 1'b0;
      end else begin : g_mid
        assign left_key = key_w[gi-1];
        assign left_gt  = gt_w[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_key = key_w[gi];
        assign top[gi]   = occ[gi];
      end else begin : g_inner
        assign right_key = key_w[gi+1];
        assign top[gi]   = occ[gi] && !occ[gi+1];
      end

      dep_cell u_cell (
        .clk_i       (clk_i),
        .ctl_i       (ctl),
        .key_i       (key_in),
        .occ_i       (occ[gi]),
        .left_key_i  (left_key),
        .left_gt_i   (left_gt),
        .right_key_i (right_key),
        .key_o       (key_w[gi]),
        .gt_o        (gt_w[gi])
      );
    end
  endgenerate

  always_comb begin
    largest = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      largest = largest | (key_w[i] & {KW{top[i]}});
    end
  end

  assign smallest = key_w[0] & {KW{occ[0]}};
  assign cnt_ext  = {7'd0, count_q};

  always_comb begin
    pend_d = pend_q;
    if (move)   pend_d = 1'b0;
    if (accept) pend_d = 1'b1;
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (move)          out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) pend_drop_q <= dropped;
    if (move)   out_data_q  <= {pend_drop_q, cnt_ext[6:0], smallest, largest};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
